/* rtl/core/fbc_pkg.sv */
package fbc_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH     = 4;
   localparam int RSP_DEPTH       = 2;
   localparam int NUM_PLANES      = 6;
   localparam int NUM_COLS        = 4;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_VERTEX = 1'b1
   } fbc_op_type;

   typedef enum logic [2:0] {
      CULL_FAR    = 3'd0,
      CULL_NEAR   = 3'd1,
      CULL_LEFT   = 3'd2,
      CULL_RIGHT  = 3'd3,
      CULL_TOP    = 3'd4,
      CULL_BOTTOM = 3'd5,
      CULL_NONE   = 3'd6
   } fbc_plane_type;

   // row combined with row 3 for each plane, and whether it is subtracted
   localparam logic [1:0] PLANE_ROW_SEL [NUM_PLANES] = '{2'd2, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1};
   localparam logic       PLANE_SUB     [NUM_PLANES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

   localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic        command;
      logic [1:0]  column_index;
      logic [31:0] row0_value;
      logic [31:0] row1_value;
      logic [31:0] row2_value;
      logic [31:0] row3_value;
      logic [31:0] vertex_x;
      logic [31:0] vertex_y;
      logic [31:0] vertex_z;
      logic        last_vertex;
   } req_type;

   typedef struct packed {
      logic       visible;
      logic [2:0] culling_plane;
   } rsp_type;

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         return s[64] ? SUM_MIN : SUM_MAX;
      end
      return s[63:0];
   endfunction

endpackage

/* rtl/core/frustum_box_cull.sv */
// Path: only a vertex word flagged last pushes a result to the result queue,
//   via input register, command queue, two multiply stages, three add stages.
// Throughput: one word per cycle, matrix column or vertex alike; the
//   back-end pipe stalls only while the result queue is full.
// Reset: synchronous, active high; clears both queues, the pipe valid bits,
//   the plane coefficients (matrix all zero) and sets the outside flags.
module frustum_box_cull #(
   parameter int COORD_WIDTH = fbc_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = fbc_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  fbc_pkg::req_type req_data,
   output logic             req_full,
   input  logic             rsp_pop,
   output fbc_pkg::rsp_type rsp_data,
   output logic             rsp_empty
);
   import fbc_pkg::*;

   // queue word: op, column, last flag, four coordinate lanes
   localparam int QW = 4*COORD_WIDTH + 4;
   localparam int RW = $bits(rsp_type);

   logic          q_push, q_full, q_pop, q_empty;
   logic [QW-1:0] q_in_word, q_head_word;
   logic          r_push, r_full;
   rsp_type       r_word;
   logic [RW-1:0] r_head;

   // front: register the request word and classify it into the queue format
   fbc_front #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_push(req_push),
      .req_data(req_data),
      .req_full(req_full),
      .q_push  (q_push),
      .q_word  (q_in_word),
      .q_full  (q_full)
   );

   // short command queue decouples the front from the back-end pipe
   fbc_fifo #(
      .WIDTH(QW),
      .DEPTH(QUEUE_DEPTH)
   ) u_cmd_q (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_word(q_in_word),
      .full     (q_full),
      .pop      (q_pop),
      .head_word(q_head_word),
      .empty    (q_empty)
   );

   // back: apply matrix loads, run plane distances, track outside flags
   fbc_back #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_word  (q_head_word),
      .q_pop   (q_pop),
      .rsp_push(r_push),
      .rsp_word(r_word),
      .rsp_full(r_full)
   );

   // result queue holds finished words while the consumer stalls
   fbc_fifo #(
      .WIDTH(RW),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .push     (r_push),
      .push_word(r_word),
      .full     (r_full),
      .pop      (rsp_pop),
      .head_word(r_head),
      .empty    (rsp_empty)
   );

   assign rsp_data = rsp_type'(r_head);

endmodule

/* rtl/core/fbc_fifo.sv */
module fbc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_word,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head_word,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

/* rtl/core/fbc_front.sv */
module fbc_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   input  fbc_pkg::req_type          req_data,
   output logic                      req_full,
   output logic                      q_push,
   output logic [4*COORD_WIDTH+3:0]  q_word,
   input  logic                      q_full
);
   import fbc_pkg::*;

   localparam int CW = COORD_WIDTH;

   typedef struct packed {
      fbc_op_type          op;
      logic [1:0]          col;
      logic                last;
      logic [3:0][CW-1:0]  data;
   } qword_type;

   logic               valid_ff, valid_in;
   qword_type          word_ff, word_in;
   logic [3:0][31:0]   raw;
   logic               accept;

   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff && !q_full;
   assign q_word   = word_ff;
   assign valid_in = accept || (valid_ff && q_full);

   // route the fields a command uses into the four data lanes
   always_comb begin
      if (req_data.command) begin
         raw = {32'd0, req_data.vertex_z, req_data.vertex_y, req_data.vertex_x};
      end else begin
         raw = {req_data.row3_value, req_data.row2_value,
                req_data.row1_value, req_data.row0_value};
      end
   end

   for (genvar i = 0; i < 4; i++) begin : g_lane
      if (CW <= 32) begin : g_trunc
         assign word_in.data[i] = raw[i][CW-1:0];
      end else begin : g_zext
         assign word_in.data[i] = {{(CW-32){1'b0}}, raw[i]};
      end
   end

   assign word_in.op   = req_data.command ? OP_VERTEX : OP_LOAD;
   assign word_in.col  = req_data.column_index;
   assign word_in.last = req_data.last_vertex;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff <= word_in;
      end
   end

endmodule

/* rtl/core/fbc_back.sv */
module fbc_back #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_empty,
   input  logic [4*COORD_WIDTH+3:0]  q_word,
   output logic                      q_pop,
   output logic                      rsp_push,
   output fbc_pkg::rsp_type          rsp_word,
   input  logic                      rsp_full
);
   import fbc_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int H   = CW / 2;
   localparam int PW  = 2*CW + 2;
   localparam int DW  = CW + 1 + FRAC_BITS;
   localparam int EW0 = (PW > DW) ? PW : DW;
   localparam int EW  = (EW0 > 65) ? EW0 : 65;
   localparam logic signed [EW-1:0] PMAX = EW'(SUM_MAX);
   localparam logic signed [EW-1:0] PMIN = -PMAX;

   typedef struct packed {
      fbc_op_type          op;
      logic [1:0]          col;
      logic                last;
      logic [3:0][CW-1:0]  data;
   } qword_type;

   qword_type head;

   logic signed [CW:0]       coef_ff [NUM_PLANES][NUM_COLS];
   logic signed [CW+H+1:0]   pl_ff   [NUM_PLANES][3];
   logic signed [2*CW-H:0]   ph_ff   [NUM_PLANES][3];
   logic signed [CW:0]       c3_ff   [NUM_PLANES];
   logic signed [63:0]       p_ff    [NUM_PLANES][4];
   logic signed [63:0]       s3_ff   [NUM_PLANES];
   logic signed [63:0]       p2_3_ff [NUM_PLANES];
   logic signed [63:0]       p3_3_ff [NUM_PLANES];
   logic signed [63:0]       s4_ff   [NUM_PLANES];
   logic signed [63:0]       p3_4_ff [NUM_PLANES];
   logic [NUM_PLANES-1:0]    inside_ff;
   logic [NUM_PLANES-1:0]    flags_ff, flags_in, flags_acc;
   logic                     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic                     l1_ff, l2_ff, l3_ff, l4_ff, l5_ff;
   logic                     adv, load;
   logic [2:0]               plane_sel;

   function automatic logic signed [63:0] sat_prod(input logic signed [EW-1:0] v);
      if (v > PMAX) begin
         return PMAX[63:0];
      end
      if (v < PMIN) begin
         return PMIN[63:0];
      end
      return v[63:0];
   endfunction

   assign head  = qword_type'(q_word);
   // hold the whole pipe only while a result has nowhere to go
   assign adv   = !(v5_ff && l5_ff && rsp_full);
   assign q_pop = !q_empty && adv;
   assign load  = q_pop && (head.op == OP_LOAD);

   // plane coefficients for the loaded column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            for (int c = 0; c < NUM_COLS; c++) begin
               coef_ff[p][c] <= '0;
            end
         end
      end else if (load) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            if (PLANE_SUB[p]) begin
               coef_ff[p][head.col] <= $signed({head.data[3][CW-1], head.data[3]})
                  - $signed({head.data[PLANE_ROW_SEL[p]][CW-1], head.data[PLANE_ROW_SEL[p]]});
            end else begin
               coef_ff[p][head.col] <= $signed({head.data[3][CW-1], head.data[3]})
                  + $signed({head.data[PLANE_ROW_SEL[p]][CW-1], head.data[PLANE_ROW_SEL[p]]});
            end
         end
      end
   end

   // stage 1: split products, vertex coordinate cut in a low and a high half
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            for (int k = 0; k < 3; k++) begin
               pl_ff[p][k] <= coef_ff[p][k] * $signed({1'b0, head.data[k][H-1:0]});
               ph_ff[p][k] <= coef_ff[p][k] * $signed(head.data[k][CW-1:H]);
            end
            c3_ff[p] <= coef_ff[p][3];
         end
         l1_ff <= head.last;
      end
   end

   // stage 2: recombine and saturate each term
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            for (int k = 0; k < 3; k++) begin
               p_ff[p][k] <= sat_prod((EW'(ph_ff[p][k]) <<< H) + EW'(pl_ff[p][k]));
            end
            p_ff[p][3] <= sat_prod(EW'(c3_ff[p]) <<< FRAC_BITS);
         end
         l2_ff <= l1_ff;
      end
   end

   // stages 3 to 5: saturating sum in model order, then the sign
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < NUM_PLANES; p++) begin
            s3_ff[p]   <= sat_add64(p_ff[p][0], p_ff[p][1]);
            p2_3_ff[p] <= p_ff[p][2];
            p3_3_ff[p] <= p_ff[p][3];
            s4_ff[p]   <= sat_add64(s3_ff[p], p2_3_ff[p]);
            p3_4_ff[p] <= p3_3_ff[p];
            inside_ff[p] <= (sat_add64(s4_ff[p], p3_4_ff[p]) >= 64'sd0);
         end
         l3_ff <= l2_ff;
         l4_ff <= l3_ff;
         l5_ff <= l4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= q_pop && (head.op == OP_VERTEX);
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   // accumulate outside flags, pick the first plane still fully outside
   always_comb begin
      flags_acc = flags_ff & ~inside_ff;
      plane_sel = 3'(CULL_NONE);
      for (int p = NUM_PLANES-1; p >= 0; p--) begin
         if (flags_acc[p]) begin
            plane_sel = 3'(p);
         end
      end
      flags_in = flags_ff;
      if (v5_ff && adv) begin
         flags_in = l5_ff ? '1 : flags_acc;
      end
   end

   assign rsp_push               = v5_ff && l5_ff && adv;
   assign rsp_word.visible       = (flags_acc == '0);
   assign rsp_word.culling_plane = plane_sel;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '1;
      end else begin
         flags_ff <= flags_in;
      end
   end

endmodule

/* rtl/core/fbc_checker.sv */
module fbc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_pop,
   input fbc_pkg::rsp_type rsp_data,
   input logic             rsp_empty
);
   import fbc_pkg::*;

   // no result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // input side open right after reset
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full after reset");

   // visible iff no culling plane
   a_vis_plane: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.visible == (rsp_data.culling_plane == CULL_NONE)))
      else $error("visible flag disagrees with culling plane");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("result dropped or changed before pop");

endmodule

bind frustum_box_cull fbc_checker u_fbc_checker (
   .clock    (clock),
   .reset    (reset),
   .req_full (req_full),
   .rsp_pop  (rsp_pop),
   .rsp_data (rsp_data),
   .rsp_empty(rsp_empty)
);
